FILE: sv/odt_pkg.sv
// Shared types and constants for the ordered dither threshold block.
package odt_pkg;

  // Default threshold store depth.
  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  // Queue depths between the front and the back, and ahead of the result ports.
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 8;

  // Field widths.
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned DIV_W   = 39;
  localparam int unsigned IW_W    = 16;
  localparam int unsigned EIDX_W  = 10;
  localparam int unsigned EVAL_W  = 31;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned PROD_W  = 47;

  localparam logic [PIX_W-1:0] PIX_FULL     = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_ZERO     = 8'h00;
  localparam logic [15:0]      ENTRY_SCALE  = 16'd65280;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_MATRIX_WIDTH  = 2'd0,
    CFG_MATRIX_HEIGHT = 2'd1,
    CFG_DIVISOR_Q8    = 2'd2,
    CFG_IMAGE_WIDTH   = 2'd3
  } cfg_idx_e;

  // Work classes handed from the front to the back.
  typedef enum logic [1:0] {
    OP_SKIP  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PIXEL = 2'd2
  } op_e;

  typedef struct packed {
    logic [SIZE_W-1:0] matrix_width;
    logic [SIZE_W-1:0] matrix_height;
    logic [DIV_W-1:0]  divisor_q8;
    logic [IW_W-1:0]   image_width;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [PIX_W-1:0]  pix_inv;   // 255 - pixel
    logic [EVAL_W-1:0] value;
  } cmd_t;

endpackage

FILE: sv/ordered_dither_threshold.sv
// Ordered dither threshold block: config registers, front, queues and back.
// Throughput: one beat per cycle on both sides, loads and pixels alike, unless the command
//   queue is full, the result queue is empty or a pixel waits for result credit.
// Pixel path: command queue, store read, multiply, then compare into the result queue.
// The result rate is bounded by the single threshold store port.
// Reset: rst_ni clears position, queues and config to defaults; the
//   threshold store has no reset and must be loaded before use.
module ordered_dither_threshold #(
  parameter int unsigned MAX_ENTRIES = odt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input item channel
  input  logic                         push,
  output logic                         full,
  input  logic                         func_i,
  input  logic [odt_pkg::PIX_W-1:0]    pixel_value_i,
  input  logic                         frame_start_i,
  input  logic [odt_pkg::EIDX_W-1:0]   entry_index_i,
  input  logic [odt_pkg::EVAL_W-1:0]   entry_value_i,
  // result channel
  output logic                         empty,
  input  logic                         pop,
  output logic [odt_pkg::PIX_W-1:0]    out_value_o,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [odt_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [odt_pkg::DIV_W-1:0]    cfg_data_i
);
  import odt_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_ENTRIES);
  localparam int unsigned MQW = $bits(cmd_t) + AW;
  localparam int unsigned OCW = $clog2(OUT_DEPTH+1);

  cfg_t           cfg_q, cfg_d;
  logic           in_accept;
  logic           fe_valid;
  cmd_t           fe_cmd, bk_cmd;
  logic [AW-1:0]  fe_addr, bk_addr;
  logic           mq_empty, mq_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mq_count;
  logic [MQW-1:0] mq_rdata;
  logic           bk_push, bk_bit;
  logic [1:0]     bk_inflight;
  logic           oq_full, oq_bit;
  logic [OCW-1:0] oq_count;

  // Config registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MATRIX_WIDTH:  cfg_d.matrix_width  = cfg_data_i[SIZE_W-1:0];
        CFG_MATRIX_HEIGHT: cfg_d.matrix_height = cfg_data_i[SIZE_W-1:0];
        CFG_DIVISOR_Q8:    cfg_d.divisor_q8    = cfg_data_i;
        CFG_IMAGE_WIDTH:   cfg_d.image_width   = cfg_data_i[IW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.matrix_width  <= SIZE_W'(4);
      cfg_q.matrix_height <= SIZE_W'(4);
      cfg_q.divisor_q8    <= DIV_W'(4096);
      cfg_q.image_width   <= IW_W'(640);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // An input beat is taken whenever the command queue has room.
  assign in_accept = push && !full;

  odt_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (in_accept),
    .func_i        (func_i),
    .pixel_value_i (pixel_value_i),
    .frame_start_i (frame_start_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .cmd_valid_o   (fe_valid),
    .cmd_o         (fe_cmd),
    .cmd_addr_o    (fe_addr)
  );

  // Command queue decouples classification from store access.
  odt_queue #(
    .WIDTH (MQW),
    .DEPTH (MID_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .wdata_i ({fe_cmd, fe_addr}),
    .full_o  (full),
    .pop_i   (mq_pop),
    .rdata_o (mq_rdata),
    .empty_o (mq_empty),
    .count_o (mq_count)
  );

  assign bk_cmd  = cmd_t'(mq_rdata[MQW-1:AW]);
  assign bk_addr = mq_rdata[AW-1:0];

  odt_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .divisor_q8_i (cfg_q.divisor_q8),
    .cmd_avail_i  (!mq_empty),
    .cmd_i        (bk_cmd),
    .cmd_addr_i   (bk_addr),
    .cmd_pop_o    (mq_pop),
    .out_count_i  (oq_count),
    .res_push_o   (bk_push),
    .res_bit_o    (bk_bit),
    .inflight_o   (bk_inflight)
  );

  // Result queue holds one bit per result; expand to 0 or 255 on the way out.
  odt_queue #(
    .WIDTH (1),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bk_push),
    .wdata_i (bk_bit),
    .full_o  (oq_full),
    .pop_i   (pop),
    .rdata_o (oq_bit),
    .empty_o (empty),
    .count_o (oq_count)
  );

  assign out_value_o = oq_bit ? PIX_FULL : PIX_ZERO;

  // The back end never pushes a result into a full result queue.
  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_push |-> !oq_full)
    else $error("result pushed into full result queue");

  // Queued plus in-flight results never exceed the result queue depth.
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(oq_count) + 32'(bk_inflight)) <= 32'(OUT_DEPTH))
    else $error("result credit exceeded");

  // The back end pops only a command that is present.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mq_pop |-> !mq_empty)
    else $error("command popped from empty queue");

  // Command queue count stays within its depth.
  a_cmd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(mq_count) <= 32'(MID_DEPTH))
    else $error("command queue count out of range");

endmodule

FILE: sv/odt_queue.sv
// Small register queue with occupancy count.
module odt_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/odt_front.sv
// Front end: classify input beats and track the raster and matrix position.
module odt_front #(
  parameter int unsigned MAX_ENTRIES = odt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  odt_pkg::cfg_t                     cfg_i,
  input  logic                              accept_i,
  input  logic                              func_i,
  input  logic [odt_pkg::PIX_W-1:0]         pixel_value_i,
  input  logic                              frame_start_i,
  input  logic [odt_pkg::EIDX_W-1:0]        entry_index_i,
  input  logic [odt_pkg::EVAL_W-1:0]        entry_value_i,
  output logic                              cmd_valid_o,
  output odt_pkg::cmd_t                     cmd_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]    cmd_addr_o
);
  import odt_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);

  logic [IW_W-1:0]   lp_q, lp_d, lp_cur;
  logic [6:0]        pc_q, pc_d, pc_cur;
  logic [6:0]        pr_q, pr_d, pr_cur;
  logic [AW-1:0]     rb_q, rb_d, rb_cur;
  logic [AW-1:0]     addr_q, addr_d, addr_cur;

  logic [SIZE_W-1:0] mw, mh;
  logic [IW_W-1:0]   iw;
  logic [IW_W:0]     lp_inc;
  logic [7:0]        pc_inc, pr_inc;
  logic [AW:0]       rb_sum, addr_inc;
  logic [AW-1:0]     mw_mod;
  logic [AW-1:0]     mod_tab [256];
  logic [31:0]       eidx_ext;

  // Matrix width modulo store depth, as a constant table.
  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tab[g] = AW'(g % MAX_ENTRIES);
  end

  always_comb begin
    if (cfg_i.matrix_width == '0) begin
      mw = SIZE_W'(1);
    end else if (cfg_i.matrix_width > SIZE_W'(128)) begin
      mw = SIZE_W'(128);
    end else begin
      mw = cfg_i.matrix_width;
    end
    if (cfg_i.matrix_height == '0) begin
      mh = SIZE_W'(1);
    end else if (cfg_i.matrix_height > SIZE_W'(128)) begin
      mh = SIZE_W'(128);
    end else begin
      mh = cfg_i.matrix_height;
    end
    iw     = (cfg_i.image_width == '0) ? IW_W'(1) : cfg_i.image_width;
    mw_mod = mod_tab[mw];
  end

  // Position update for a pixel beat.
  always_comb begin
    lp_cur   = frame_start_i ? '0 : lp_q;
    pc_cur   = frame_start_i ? '0 : pc_q;
    pr_cur   = frame_start_i ? '0 : pr_q;
    rb_cur   = frame_start_i ? '0 : rb_q;
    addr_cur = frame_start_i ? '0 : addr_q;

    lp_inc   = {1'b0, lp_cur} + (IW_W+1)'(1);
    pc_inc   = {1'b0, pc_cur} + 8'd1;
    pr_inc   = {1'b0, pr_cur} + 8'd1;
    rb_sum   = {1'b0, rb_cur} + {1'b0, mw_mod};
    addr_inc = {1'b0, addr_cur} + (AW+1)'(1);

    lp_d   = lp_q;
    pc_d   = pc_q;
    pr_d   = pr_q;
    rb_d   = rb_q;
    addr_d = addr_q;

    if (accept_i && func_i) begin
      if (lp_inc >= {1'b0, iw}) begin
        lp_d = '0;
        pc_d = '0;
        if (pr_inc >= mh) begin
          pr_d   = '0;
          rb_d   = '0;
          addr_d = '0;
        end else begin
          pr_d = pr_inc[6:0];
          if (rb_sum >= (AW+1)'(MAX_ENTRIES)) begin
            rb_d = AW'(rb_sum - (AW+1)'(MAX_ENTRIES));
          end else begin
            rb_d = rb_sum[AW-1:0];
          end
          addr_d = rb_d;
        end
      end else begin
        lp_d = lp_inc[IW_W-1:0];
        rb_d = rb_cur;
        pr_d = pr_cur;
        if (pc_inc >= mw) begin
          pc_d   = '0;
          addr_d = rb_cur;
        end else begin
          pc_d   = pc_inc[6:0];
          addr_d = (addr_inc == (AW+1)'(MAX_ENTRIES)) ? '0 : addr_inc[AW-1:0];
        end
      end
    end
  end

  // Classify the beat for the back end.
  always_comb begin
    eidx_ext        = 32'(entry_index_i);
    cmd_valid_o     = accept_i;
    cmd_o.pix_inv   = PIX_FULL - pixel_value_i;
    cmd_o.value     = entry_value_i;
    if (func_i) begin
      cmd_o.op   = OP_PIXEL;
      cmd_addr_o = addr_cur;
    end else begin
      cmd_o.op   = (eidx_ext < 32'(MAX_ENTRIES)) ? OP_LOAD : OP_SKIP;
      cmd_addr_o = eidx_ext[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q   <= '0;
      pc_q   <= '0;
      pr_q   <= '0;
      rb_q   <= '0;
      addr_q <= '0;
    end else begin
      lp_q   <= lp_d;
      pc_q   <= pc_d;
      pr_q   <= pr_d;
      rb_q   <= rb_d;
      addr_q <= addr_d;
    end
  end

endmodule

FILE: sv/odt_back.sv
// Back end: threshold store, multiply and compare pipeline.
module odt_back #(
  parameter int unsigned MAX_ENTRIES = odt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [odt_pkg::DIV_W-1:0]               divisor_q8_i,
  input  logic                                    cmd_avail_i,
  input  odt_pkg::cmd_t                           cmd_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0]          cmd_addr_i,
  output logic                                    cmd_pop_o,
  input  logic [$clog2(odt_pkg::OUT_DEPTH+1)-1:0] out_count_i,
  output logic                                    res_push_o,
  output logic                                    res_bit_o,
  output logic [1:0]                              inflight_o
);
  import odt_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(OUT_DEPTH+1);

  logic [EVAL_W-1:0] mem_q [MAX_ENTRIES];
  logic [EVAL_W-1:0] rd_q;
  logic              wr_en, rd_en;
  logic              s1_v_q, s2_v_q;
  logic [PIX_W-1:0]  s1_pix_inv_q;
  logic [PROD_W-1:0] d_q, e_q;
  logic [CW+1:0]     credit_sum;

  // Issue a pixel only when its result has a guaranteed slot.
  always_comb begin
    credit_sum = (CW+2)'(out_count_i) + (CW+2)'(s1_v_q) + (CW+2)'(s2_v_q);
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    cmd_pop_o  = 1'b0;
    if (cmd_avail_i) begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          wr_en     = 1'b1;
          cmd_pop_o = 1'b1;
        end
        OP_PIXEL: begin
          if (credit_sum < (CW+2)'(OUT_DEPTH)) begin
            rd_en     = 1'b1;
            cmd_pop_o = 1'b1;
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cmd_addr_i] <= cmd_i.value;
    end
    if (rd_en) begin
      rd_q <= mem_q[cmd_addr_i];
    end
  end

  // Payload stages; compare entry*65280 against (255 - pixel)*divisor.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_pix_inv_q <= cmd_i.pix_inv;
    end
    if (s1_v_q) begin
      d_q <= PROD_W'(s1_pix_inv_q) * PROD_W'(divisor_q8_i);
      e_q <= PROD_W'(rd_q) * PROD_W'(ENTRY_SCALE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= rd_en;
      s2_v_q <= s1_v_q;
    end
  end

  assign res_push_o = s2_v_q;
  assign res_bit_o  = (e_q > d_q);
  assign inflight_o = {1'b0, s1_v_q} + {1'b0, s2_v_q};

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the ordered dither threshold block.
`timescale 1ns / 1ps

module tb_top;
  import odt_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int unsigned TIMEOUT_CYCLES = 400_000;
  localparam int unsigned DRAIN_CYCLES = 12;   // covers a load still in flight
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_BEATS = 115;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned STORE_DEPTH = 1024;

  // Item kinds on func_i.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef enum int {POP_FREE, POP_RANDOM, POP_PATTERN} pop_style_e;

  typedef struct packed {
    logic              func;
    logic [PIX_W-1:0]  pixel;
    logic              frame_start;
    logic [EIDX_W-1:0] entry_index;
    logic [EVAL_W-1:0] entry_value;
  } dither_beat_t;

  // Raster position: column in the line, matrix column, matrix row, row base.
  typedef struct packed {
    logic [15:0]       col;
    logic [6:0]        mcol;
    logic [6:0]        mrow;
    logic [EIDX_W-1:0] base;
  } raster_pos_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              push = 1'b0;
  logic              full;
  logic              func_i = 1'b0;
  logic [PIX_W-1:0]  pixel_value_i = '0;
  logic              frame_start_i = 1'b0;
  logic [EIDX_W-1:0] entry_index_i = '0;
  logic [EVAL_W-1:0] entry_value_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [PIX_W-1:0]  out_value_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = '0;
  logic [DIV_W-1:0]  cfg_data_i = '0;

  ordered_dither_threshold dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .pixel_value_i (pixel_value_i),
    .frame_start_i (frame_start_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .empty         (empty),
    .pop           (pop),
    .out_value_o   (out_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Register values as written into the block; starts at the reset defaults.
  cfg_t live_cfg = '{8'd4, 8'd4, 39'd4096, 16'd640};

  // Beats waiting to go out, and dithered levels waiting to come back.
  dither_beat_t beat_backlog[$];
  logic [PIX_W-1:0] pending_levels[$];

  // Predicted block state, advanced at each accepted beat.
  logic [EVAL_W-1:0] shadow_store[STORE_DEPTH];
  raster_pos_t       shadow_pos = '0;

  // Stimulus-side view: position and store contents as the backlog will leave them.
  logic [EVAL_W-1:0] plan_store[STORE_DEPTH];
  bit                plan_written[STORE_DEPTH];
  raster_pos_t       plan_pos = '0;

  int unsigned beats_queued = 0;
  int unsigned beats_taken = 0;
  int unsigned fails = 0;

  // Sender burst state.
  dither_beat_t on_port = '0;
  logic         offer;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;

  // Receiver stall state.
  pop_style_e   pop_style = POP_FREE;
  int unsigned  pop_style_left = 0;
  logic [7:0]   pop_mask = '0;
  logic         stall;
  int unsigned  hold_left = 0;
  int unsigned  holds_done = 0;
  int unsigned  pops_seen = 0;

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Dither arithmetic and raster walk
  // ---------------------------------------------------------------------------

  // Zero and oversized matrix sizes act as 1 and 128.
  function automatic int unsigned size_in_use(logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > 8'd128) return 128;
    return v;
  endfunction

  // The store wraps: a matrix bigger than the store aliases onto it.
  function automatic logic [EIDX_W-1:0] entry_addr(raster_pos_t p);
    return p.base + EIDX_W'(p.mcol);
  endfunction

  // Step one pixel along the raster; each counter wraps once it reaches its
  // current limit, so a shrunk size mid-frame folds the position back.
  function automatic raster_pos_t advance_pos(raster_pos_t p, cfg_t c);
    int unsigned mw, mh, iw, col, mcol, mrow;
    raster_pos_t n;
    mw = size_in_use(c.matrix_width);
    mh = size_in_use(c.matrix_height);
    iw = (c.image_width == '0) ? 1 : c.image_width;
    col = p.col + 1;
    mcol = p.mcol;
    mrow = p.mrow;
    n.base = p.base;
    if (col >= iw) begin
      col = 0;
      mcol = 0;
      mrow = mrow + 1;
      if (mrow >= mh) begin
        mrow = 0;
        n.base = '0;
      end else begin
        n.base = p.base + EIDX_W'(mw);
      end
    end else begin
      mcol = mcol + 1;
      if (mcol >= mw) mcol = 0;
    end
    n.col = col[15:0];
    n.mcol = mcol[6:0];
    n.mrow = mrow[6:0];
    return n;
  endfunction

  // Exact compare: pixel*div + entry*255*256 > 255*div, no special case for a
  // zero divisor.
  function automatic logic [PIX_W-1:0] dither_level(logic [PIX_W-1:0] pix,
                                                    logic [EVAL_W-1:0] ent,
                                                    logic [DIV_W-1:0] div);
    logic [63:0] lhs, rhs;
    lhs = 64'(pix) * 64'(div) + 64'(ent) * 64'd65280;
    rhs = 64'd255 * 64'(div);
    return (lhs > rhs) ? PIX_FULL : PIX_ZERO;
  endfunction

  // Apply one accepted beat: loads fill the store, pixels yield one level.
  function automatic void dither_update(dither_beat_t b);
    if (b.func == FUNC_LOAD) begin
      shadow_store[b.entry_index] = b.entry_value;
    end else begin
      if (b.frame_start) shadow_pos = '0;
      pending_levels.push_back(dither_level(b.pixel, shadow_store[entry_addr(shadow_pos)],
                                            live_cfg.divisor_q8));
      shadow_pos = advance_pos(shadow_pos, live_cfg);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------

  // Thresholds mostly on the scale where the current divisor makes both
  // levels likely, now and then full range or the extremes.
  function automatic logic [EVAL_W-1:0] pick_threshold();
    longint span;
    span = (longint'(live_cfg.divisor_q8) * 255) / 65280 + 2;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    case ($urandom_range(0, 7))
      0: return EVAL_W'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return EVAL_W'($urandom_range(0, int'(span)));
    endcase
  endfunction

  // Half the loads land inside the matrix in use, the rest anywhere.
  function automatic logic [EIDX_W-1:0] pick_index();
    int unsigned cells;
    cells = size_in_use(live_cfg.matrix_width) * size_in_use(live_cfg.matrix_height);
    if (cells > STORE_DEPTH) cells = STORE_DEPTH;
    if ($urandom_range(0, 1) != 0) return EIDX_W'($urandom_range(0, cells - 1));
    return EIDX_W'($urandom_range(0, STORE_DEPTH - 1));
  endfunction

  // A pixel one step below, at or above the cut for this entry.
  function automatic logic [PIX_W-1:0] pixel_near_cut(logic [EVAL_W-1:0] ent);
    longint q;
    int off;
    if (live_cfg.divisor_q8 == '0) return PIX_W'($urandom);
    off = $urandom_range(0, 2);
    q = 255 - (longint'(ent) * 65280) / longint'(live_cfg.divisor_q8) + off - 1;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[PIX_W-1:0];
  endfunction

  function automatic void add_load(logic [EIDX_W-1:0] idx, logic [EVAL_W-1:0] val);
    dither_beat_t b;
    b.func = FUNC_LOAD;
    b.pixel = PIX_W'($urandom);       // ignored on loads
    b.frame_start = 1'($urandom_range(0, 1));
    b.entry_index = idx;
    b.entry_value = val;
    beat_backlog.push_back(b);
    beats_queued++;
    plan_store[idx] = val;
    plan_written[idx] = 1'b1;
  endfunction

  // Queue a pixel; load its entry first if nothing has been written there yet.
  function automatic void add_pixel(logic fs, logic [PIX_W-1:0] pix, bit near_cut);
    dither_beat_t b;
    logic [EIDX_W-1:0] a;
    if (fs) plan_pos = '0;
    a = entry_addr(plan_pos);
    if (!plan_written[a]) add_load(a, pick_threshold());
    b.func = FUNC_PIXEL;
    b.pixel = near_cut ? pixel_near_cut(plan_store[a]) : pix;
    b.frame_start = fs;
    b.entry_index = EIDX_W'($urandom);  // ignored on pixels
    b.entry_value = EVAL_W'($urandom);
    beat_backlog.push_back(b);
    beats_queued++;
    plan_pos = advance_pos(plan_pos, live_cfg);
  endfunction

  // Mostly raster runs with random content; some loads and stray frame starts
  // break into them.
  function automatic void random_phase(int unsigned count);
    int unsigned r;
    logic fs;
    bit open_frame;
    open_frame = ($urandom_range(0, 1) != 0);
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      fs = (k == 0 && open_frame) || ($urandom_range(0, 59) == 0);
      if (r < 12) add_load(pick_index(), pick_threshold());
      else if (r < 45) add_pixel(fs, '0, 1'b1);
      else if (r < 52) add_pixel(fs, ($urandom_range(0, 1) != 0) ? PIX_FULL : PIX_ZERO, 1'b0);
      else add_pixel(fs, PIX_W'($urandom), 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration channel
  // ---------------------------------------------------------------------------

  task automatic write_reg(cfg_idx_e idx, logic [DIV_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MATRIX_WIDTH:  live_cfg.matrix_width = data[SIZE_W-1:0];
      CFG_MATRIX_HEIGHT: live_cfg.matrix_height = data[SIZE_W-1:0];
      CFG_DIVISOR_Q8:    live_cfg.divisor_q8 = data;
      CFG_IMAGE_WIDTH:   live_cfg.image_width = data[IW_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_setting(cfg_t s);
    write_reg(CFG_MATRIX_WIDTH, DIV_W'(s.matrix_width));
    write_reg(CFG_MATRIX_HEIGHT, DIV_W'(s.matrix_height));
    write_reg(CFG_DIVISOR_Q8, s.divisor_q8);
    write_reg(CFG_IMAGE_WIDTH, DIV_W'(s.image_width));
  endtask

  // Wait until every queued beat is in and every level is back, then let any
  // trailing load settle before the registers change.
  task automatic drain();
    while (beats_taken != beats_queued || pending_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of beats separated by random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      offer = push;
      // Retire the beat taken at this edge.
      if (push && !full) begin
        dither_update(on_port);
        beats_taken++;
        offer = 1'b0;
      end
      // Load the next beat unless a gap is running; hold push high across a burst.
      if (!offer && beat_backlog.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          on_port = beat_backlog.pop_front();
          func_i <= on_port.func;
          pixel_value_i <= on_port.pixel;
          frame_start_i <= on_port.frame_start;
          entry_index_i <= on_port.entry_index;
          entry_value_i <= on_port.entry_value;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      push <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: check each popped level, stall on a changing pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_levels.size() == 0) begin
          $error("out_value: no level expected, actual %0d", out_value_o);
          fails++;
        end else if (out_value_o !== pending_levels[0]) begin
          $error("out_value mismatch: expected %0d, actual %0d",
                 pending_levels[0], out_value_o);
          fails++;
          void'(pending_levels.pop_front());
        end else begin
          void'(pending_levels.pop_front());
        end
      end
      // Switch stall style when the current one runs out: none, coin flips, rotating mask.
      if (pop_style_left == 0) begin
        pop_style = pop_style_e'($urandom_range(0, 2));
        pop_style_left = $urandom_range(16, 96);
        pop_mask = 8'($urandom);
      end else begin
        pop_style_left--;
      end
      case (pop_style)
        POP_FREE:   stall = 1'b0;
        POP_RANDOM: stall = 1'($urandom_range(0, 1));
        default: begin
          stall = pop_mask[0];
          pop_mask = {pop_mask[0], pop_mask[7:1]};
        end
      endcase
      pop <= !stall && (hold_left == 0);
    end
  end

  // Twice in the run, stop popping for a long stretch so the block backs up
  // and deasserts its input side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      holds_done <= 0;
      pops_seen <= 0;
    end else begin
      if (pop && !empty) pops_seen <= pops_seen + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (holds_done < 2 && pops_seen >= 150 + 550 * holds_done) begin
        hold_left <= HOLD_CYCLES;
        holds_done <= holds_done + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed checks, then random phases under varied settings
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t setting;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Divisor 255.0 turns the compare into pixel + entry > 255; 2x2 matrix on
    // 3-pixel lines walks column wrap, line wrap and row wrap in a few pixels.
    apply_setting('{8'd2, 8'd2, 39'd65280, 16'd3});
    add_load(10'd0, 31'd0);
    add_load(10'd1, 31'd255);
    add_load(10'd2, 31'h7FFF_FFFF);
    add_load(10'd3, 31'd128);
    add_load(10'h3FF, 31'h2AAA_AAAA);      // top index, alternating bits
    add_load(10'h3FF, 31'h5555_5555);      // overwrite with the other pattern
    add_pixel(1'b1, PIX_FULL, 1'b0);       // sum exactly 255: stays dark
    add_pixel(1'b0, PIX_ZERO, 1'b0);       // entry 255 alone: also at the cut
    add_pixel(1'b0, 8'd1, 1'b0);           // matrix column wrapped back to 0
    add_pixel(1'b0, PIX_ZERO, 1'b0);       // next line, row 1, largest entry
    add_pixel(1'b0, 8'd128, 1'b0);         // 128 + 128 just over
    add_pixel(1'b0, 8'd127, 1'b0);
    add_pixel(1'b0, PIX_FULL, 1'b0);       // row wrap back to the top
    add_pixel(1'b1, PIX_ZERO, 1'b0);       // frame start mid-line
    add_pixel(1'b0, 8'd254, 1'b0);
    add_pixel(1'b1, 8'hAA, 1'b0);
    add_pixel(1'b0, 8'h55, 1'b0);
    drain();

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: setting = '{8'd4, 8'd4, 39'd4096, 16'd13};
        1: setting = '{8'd1, 8'd1, 39'd1, 16'd1};
        2: setting = '{8'd128, 8'd128, 39'h7F_FFFF_FFFF, 16'hFFFF};
        3: setting = '{8'd128, 8'd128, 39'd300000, 16'd5};   // rows spill past the store
        4: setting = '{8'd0, 8'd0, 39'd0, 16'd0};            // zero sizes, zero divisor
        5: setting = '{8'd255, 8'd200, 39'd65280, 16'd7};    // oversized matrix
        6: setting = '{8'd3, 8'd5, 39'd65280, 16'd11};
        default: begin
          setting.matrix_width = SIZE_W'($urandom_range(0, 255));
          setting.matrix_height = SIZE_W'($urandom_range(0, 255));
          setting.divisor_q8 = ($urandom_range(0, 3) == 0) ? DIV_W'({$urandom, $urandom})
                                                          : DIV_W'($urandom_range(1, 1 << 20));
          setting.image_width = ($urandom_range(0, 3) == 0) ? IW_W'($urandom)
                                                           : IW_W'($urandom_range(1, 48));
        end
      endcase
      // Counters carry over: no forced frame start after a size change.
      apply_setting(setting);
      random_phase(PHASE_BEATS);
      drain();
    end

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the run stalls.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb: failure");
    $finish;
  end

endmodule
